FILE: design/tegd_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// touch event gesture decoder. No dependencies.
`default_nettype none

package tegd_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int STEP_W        = $clog2(FRACTION_BITS);

	localparam int TYPE_W   = 5;
	localparam int CODE_W   = 10;
	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int DIFF_W   = VALUE_W + 1;
	localparam int MAG_W    = VALUE_W + 2;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRACTION_BITS - 1);
	localparam logic [FRAC_W-1:0] FRAC_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};

	localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
	localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_ABS  = 5'd3;

	localparam logic [CODE_W-1:0] CODE_ABS_X       = 10'd0;
	localparam logic [CODE_W-1:0] CODE_ABS_Y       = 10'd1;
	localparam logic [CODE_W-1:0] CODE_KEY_TOUCH   = 10'd330;
	localparam logic [CODE_W-1:0] CODE_SYNC_REPORT = 10'd0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DOWN = 2'd0,
		ACT_UP   = 2'd1,
		ACT_MOVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_X_MIN = 2'd0,
		REG_X_MAX = 2'd1,
		REG_Y_MIN = 2'd2,
		REG_Y_MAX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic capture;
		logic axis_y;
		logic prep;
		logic sign;
		logic classify;
		logic step;
		logic store;
		logic out_load;
	} tegd_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_full;
	} tegd_sts_t;

endpackage

`default_nettype wire

FILE: design/tegd_if.sv
// Valid/ready channel interfaces for input events and result items.
// Depends on tegd_pkg for field widths.
`default_nettype none

interface tegd_evt_if import tegd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [TYPE_W-1:0]         event_type;
	logic [CODE_W-1:0]         event_code;
	logic signed [VALUE_W-1:0] event_value;

	modport source (output valid, event_type, event_code, event_value, input ready);
	modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tegd_res_if import tegd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] touch_action;
	logic [FRAC_W-1:0]   x_fraction;
	logic [FRAC_W-1:0]   y_fraction;

	modport source (output valid, touch_action, x_fraction, y_fraction, input ready);
	modport sink   (input valid, touch_action, x_fraction, y_fraction, output ready);
endinterface

`default_nettype wire

FILE: design/tegd_ctrl.sv
// Controller state machine: input handshake and sequencing of the shared
// divider over X then Y. Depends on tegd_pkg.
`default_nettype none

module tegd_ctrl import tegd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire tegd_sts_t sts,
	output tegd_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SIGN,
		S_CLASS,
		S_DIV,
		S_STORE,
		S_WAIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && sts.emit) begin
						axis_q  <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP:  state_q <= S_SIGN;
				S_SIGN:  state_q <= S_CLASS;
				S_CLASS: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_PREP;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!sts.out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.axis_y   = axis_q;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.prep     = (state_q == S_PREP);
		cmd.sign     = (state_q == S_SIGN);
		cmd.classify = (state_q == S_CLASS);
		cmd.step     = (state_q == S_DIV);
		cmd.store    = (state_q == S_STORE);
		cmd.out_load = (state_q == S_WAIT) && !sts.out_full;
	end

endmodule

`default_nettype wire

FILE: design/tegd_dp.sv
// Datapath: range registers, held touch state, restoring divider shared
// by both axes, and the result register. Depends on tegd_pkg.
`default_nettype none

module tegd_dp import tegd_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tegd_cmd_t                 cmd,
	output tegd_sts_t                      sts,
	input  wire logic [TYPE_W-1:0]         event_type,
	input  wire logic [CODE_W-1:0]         event_code,
	input  wire logic signed [VALUE_W-1:0] event_value,
	input  wire logic                      res_ready,
	output logic                           res_valid,
	output logic [ACTION_W-1:0]            touch_action,
	output logic [FRAC_W-1:0]              x_fraction,
	output logic [FRAC_W-1:0]              y_fraction,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ADDR_W-1:0]         paddr,
	input  wire logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]              prdata
);

	typedef enum logic [1:0] {
		CLS_DIV,
		CLS_ZERO,
		CLS_ONE
	} cls_t;

	logic signed [VALUE_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [VALUE_W-1:0] held_x_q, held_y_q;
	logic                      active_q, changed_q, press_q, release_q;
	action_t                   act_q;

	logic signed [DIFF_W-1:0]  num_q, den_q;
	logic signed [MAG_W-1:0]   numm_q, denm_q;
	cls_t                      cls_q;
	logic [MAG_W-1:0]          rem_q;
	logic [FRACTION_BITS-1:0]  quo_q;
	logic [FRAC_W-1:0]         xfr_q, yfr_q;

	logic                      res_valid_q;
	action_t                   res_act_q;
	logic [FRAC_W-1:0]         res_x_q, res_y_q;

	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;
	logic                      is_report, pressed;
	logic signed [VALUE_W-1:0] raw_sel, lo_sel, hi_sel;
	logic [MAG_W-1:0]          rem_sh, den_u, rem_sub;
	logic [FRAC_W-1:0]         frac_new;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= VALUE_W'(1);
			y_min_q <= '0;
			y_max_q <= VALUE_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_X_MIN: x_min_q <= pwdata;
				REG_X_MAX: x_max_q <= pwdata;
				REG_Y_MIN: y_min_q <= pwdata;
				REG_Y_MAX: y_max_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_X_MIN: prdata = x_min_q;
			REG_X_MAX: prdata = x_max_q;
			REG_Y_MIN: prdata = y_min_q;
			REG_Y_MAX: prdata = y_max_q;
			default:   prdata = '0;
		endcase
	end

	// Event decode
	assign is_report = (event_type == TYPE_SYNC) && (event_code == CODE_SYNC_REPORT);
	assign pressed   = (event_value != '0);
	assign sts.emit  = is_report && (press_q || release_q || (active_q && changed_q));
	assign sts.out_full = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q  <= '0;
			held_y_q  <= '0;
			active_q  <= 1'b0;
			changed_q <= 1'b0;
			press_q   <= 1'b0;
			release_q <= 1'b0;
		end else if (cmd.capture) begin
			if (event_type == TYPE_ABS) begin
				if (event_code == CODE_ABS_X) begin
					held_x_q  <= event_value;
					changed_q <= 1'b1;
				end else if (event_code == CODE_ABS_Y) begin
					held_y_q  <= event_value;
					changed_q <= 1'b1;
				end
			end else if (event_type == TYPE_KEY) begin
				if (event_code == CODE_KEY_TOUCH) begin
					if (pressed && !active_q) begin
						press_q <= 1'b1;
					end
					if (!pressed && active_q) begin
						release_q <= 1'b1;
					end
					active_q <= pressed;
				end
			end else if (is_report) begin
				changed_q <= 1'b0;
				press_q   <= 1'b0;
				release_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture && is_report) begin
			if (press_q) begin
				act_q <= ACT_DOWN;
			end else if (release_q) begin
				act_q <= ACT_UP;
			end else begin
				act_q <= ACT_MOVE;
			end
		end
	end

	// Divider
	assign raw_sel = cmd.axis_y ? held_y_q : held_x_q;
	assign lo_sel  = cmd.axis_y ? y_min_q  : x_min_q;
	assign hi_sel  = cmd.axis_y ? y_max_q  : x_max_q;

	assign den_u   = denm_q;
	assign rem_sh  = {rem_q[MAG_W-2:0], 1'b0};
	assign rem_sub = rem_sh - den_u;

	always_comb begin
		case (cls_q)
			CLS_ZERO: frac_new = '0;
			CLS_ONE:  frac_new = FRAC_ONE;
			default:  frac_new = {1'b0, quo_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			num_q <= $signed({raw_sel[VALUE_W-1], raw_sel}) - $signed({lo_sel[VALUE_W-1], lo_sel});
			den_q <= $signed({hi_sel[VALUE_W-1], hi_sel}) - $signed({lo_sel[VALUE_W-1], lo_sel});
		end
		if (cmd.sign) begin
			if (den_q[DIFF_W-1]) begin
				numm_q <= -$signed({num_q[DIFF_W-1], num_q});
				denm_q <= -$signed({den_q[DIFF_W-1], den_q});
			end else begin
				numm_q <= $signed({num_q[DIFF_W-1], num_q});
				denm_q <= $signed({den_q[DIFF_W-1], den_q});
			end
		end
		if (cmd.classify) begin
			rem_q <= numm_q;
			quo_q <= '0;
			if ((denm_q == '0) || numm_q[MAG_W-1] || (numm_q == '0)) begin
				cls_q <= CLS_ZERO;
			end else if (numm_q >= denm_q) begin
				cls_q <= CLS_ONE;
			end else begin
				cls_q <= CLS_DIV;
			end
		end
		if (cmd.step) begin
			if (rem_sh >= den_u) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[FRACTION_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[FRACTION_BITS-2:0], 1'b0};
			end
		end
		if (cmd.store) begin
			if (cmd.axis_y) begin
				yfr_q <= frac_new;
			end else begin
				xfr_q <= frac_new;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_act_q <= act_q;
			res_x_q   <= xfr_q;
			res_y_q   <= yfr_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign touch_action = res_act_q;
	assign x_fraction   = res_x_q;
	assign y_fraction   = res_y_q;

endmodule

`default_nettype wire

FILE: design/touch_event_gesture_decoder.sv
// Top level of the touch event gesture decoder: controller and datapath.
// Depends on tegd_pkg, tegd_if, tegd_ctrl and tegd_dp.
//
//   channel  direction  handshake              payload
//   evt      in         valid/ready            event_type, event_code, event_value
//   res      out        valid/ready            touch_action, x_fraction, y_fraction
//   apb      in         psel/penable, pready=1 paddr, pwdata, prdata (range registers)
//
// Axis, key and ignored events are taken back to back while the controller is idle.
// A report that yields a result is worked per axis through one subtract,
// one sign fix, one range check and 16 restoring divider steps plus a
// store; X and Y share the divider one after the other.
// A report with nothing to emit only clears the edge and position flags.
// While a result waits in the output register, further items are still taken;
// a second result holds the divider until the register drains.
// Reset clears the range registers to 0..1, the held position and all flags.
`default_nettype none

module touch_event_gesture_decoder import tegd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tegd_evt_if.sink               evt,
	tegd_res_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	tegd_cmd_t cmd;
	tegd_sts_t sts;
	logic      in_ready;

	// Register access completes in a single access phase
	assign pready    = 1'b1;
	assign evt.ready = in_ready;

	tegd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tegd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.event_type   (evt.event_type),
		.event_code   (evt.event_code),
		.event_value  (evt.event_value),
		.res_ready    (res.ready),
		.res_valid    (res.valid),
		.touch_action (res.touch_action),
		.x_fraction   (res.x_fraction),
		.y_fraction   (res.y_fraction),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata)
	);

endmodule

`default_nettype wire

FILE: design/tegd_checker.sv
// Port-level checks on the gesture decoder's result channel, bound to the
// top level. Depends on tegd_pkg.
`default_nettype none

module tegd_checker import tegd_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                evt_valid,
	input wire logic                evt_ready,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire logic [ACTION_W-1:0] touch_action,
	input wire logic [FRAC_W-1:0]   x_fraction,
	input wire logic [FRAC_W-1:0]   y_fraction
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(touch_action)
			&& $stable(x_fraction) && $stable(y_fraction))
		else $error("result changed while stalled");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (touch_action == ACT_DOWN) || (touch_action == ACT_UP)
			|| (touch_action == ACT_MOVE))
		else $error("undefined touch action");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (x_fraction <= FRAC_ONE) && (y_fraction <= FRAC_ONE))
		else $error("fraction above one");

	// A result never appears the cycle after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !res_valid |=> !res_valid)
		else $error("result without divider latency");

endmodule

bind touch_event_gesture_decoder tegd_checker u_tegd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.touch_action (res.touch_action),
	.x_fraction   (res.x_fraction),
	.y_fraction   (res.y_fraction)
);

`default_nettype wire
